// ===== sv/eps_pkg.sv =====
package eps_pkg;

  // Speed is refreshed once more than this many milliseconds have elapsed.
  localparam logic [31:0] SPEED_WINDOW_MS = 32'd200;
  // Per-millisecond rate to per-minute rate: the number of milliseconds in a minute.
  localparam logic [15:0] SPEED_SCALE     = 16'd60000;
  localparam logic [15:0] RESOLUTION_RST  = 16'd1024;

  // Widths of the shared 32x16 multiplier and of the divider.
  localparam int PROD_W     = 48;
  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // APB address width: four 32-bit registers.
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_PRESET = 2'd2,
    KIND_RESET  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_DIRECTION  = 2'd0,
    REG_DIAMETER   = 2'd1,
    REG_RELATIVE   = 2'd2,
    REG_RESOLUTION = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MS_PRE = 2'd0,
    MS_NUM = 2'd1,
    MS_DEN = 2'd2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECIDE,
    ST_MUL_PRE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic        direction_invert;
    logic        diameter_mode;
    logic        relative_mode;
    logic [15:0] resolution;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     eval;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_step;
    logic     commit;
    logic     upd;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  win_ok;
    logic  res_zero;
    logic  out_free;
  } sts_t;

endpackage

// ===== sv/eps_in_if.sv =====
interface eps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] hw_count;
  logic [31:0]        time_ms;
  logic signed [31:0] preset_value;

  modport source (output valid, kind, hw_count, time_ms, preset_value, input ready);
  modport sink (input valid, kind, hw_count, time_ms, preset_value, output ready);
endinterface

// ===== sv/eps_out_if.sv =====
interface eps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] speed;
  logic               speed_updated;

  modport source (output valid, position, speed, speed_updated, input ready);
  modport sink (input valid, position, speed, speed_updated, output ready);
endinterface

// ===== sv/eps_ctrl.sv =====
module eps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  eps_pkg::sts_t sts,
  output eps_pkg::cmd_t cmd
);

  eps_pkg::state_t               state, state_next;
  logic                          upd, upd_next;
  logic [eps_pkg::DIV_CNT_W-1:0] cnt, cnt_next;

  // State register and sequencing counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eps_pkg::ST_IDLE;
      upd   <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      upd   <= upd_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    upd_next    = upd;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = eps_pkg::MS_PRE;
    cmd.upd     = upd;
    unique case (state)
      eps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = eps_pkg::ST_EVAL;
        end
      end
      eps_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        upd_next = 1'b0;
        case (sts.kind)
          eps_pkg::KIND_SAMPLE: state_next = eps_pkg::ST_DECIDE;
          eps_pkg::KIND_PRESET: state_next = eps_pkg::ST_MUL_PRE;
          default:              state_next = eps_pkg::ST_COMMIT;
        endcase
      end
      eps_pkg::ST_DECIDE: begin
        if (!sts.win_ok) begin
          state_next = eps_pkg::ST_COMMIT;
        end else begin
          upd_next   = 1'b1;
          state_next = sts.res_zero ? eps_pkg::ST_COMMIT : eps_pkg::ST_MUL_NUM;
        end
      end
      eps_pkg::ST_MUL_PRE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = eps_pkg::MS_PRE;
        state_next  = eps_pkg::ST_COMMIT;
      end
      eps_pkg::ST_MUL_NUM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = eps_pkg::MS_NUM;
        state_next  = eps_pkg::ST_MUL_DEN;
      end
      eps_pkg::ST_MUL_DEN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = eps_pkg::MS_DEN;
        cnt_next    = '0;
        state_next  = eps_pkg::ST_DIV;
      end
      eps_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == eps_pkg::DIV_CNT_W'(eps_pkg::DIV_STEPS - 1)) begin
          state_next = eps_pkg::ST_COMMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      eps_pkg::ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = eps_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // The divider runs exactly its step count and then hands over to commit.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == eps_pkg::ST_DIV && cnt == eps_pkg::DIV_CNT_W'(eps_pkg::DIV_STEPS - 1))
    |=> state == eps_pkg::ST_COMMIT)
    else $error("divider did not hand over to commit");

  // Every accepted word is evaluated in the following cycle.
  a_capture_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == eps_pkg::ST_EVAL && cmd.eval))
    else $error("accepted word was not evaluated");

  // A speed update is only flagged for sample words.
  a_upd_sample: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cmd.upd) |-> sts.kind == eps_pkg::KIND_SAMPLE)
    else $error("speed update flagged for a non-sample word");

endmodule

// ===== sv/eps_dp.sv =====
module eps_dp (
  input  logic               clk,
  input  logic               rst,
  input  eps_pkg::cfg_t      cfg,
  input  eps_pkg::cmd_t      cmd,
  output eps_pkg::sts_t      sts,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_hw_count,
  input  logic [31:0]        in_time_ms,
  input  logic [31:0]        in_preset_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_position,
  output logic [31:0]        out_speed,
  output logic               out_speed_updated
);

  localparam int PW = eps_pkg::PROD_W;

  eps_pkg::kind_t kind_r;
  logic [31:0]    a_r, time_r, preset_r;
  logic [31:0]    dt_r, mag_r;
  logic           neg_r;
  logic [PW-1:0]  q_r, den_r, rem_r;

  logic [31:0] abs_zero, rel_zero, last_t, last_p, speed_v;
  logic [31:0] abs_zero_next, rel_zero_next, last_t_next, last_p_next, speed_v_next;

  logic [31:0]   a_in, inv_cnt, dpos, src;
  logic [31:0]   mul_a;
  logic [15:0]   mul_b;
  logic [PW-1:0] prod;
  logic [PW:0]   rem_sh;
  logic          ge;
  logic [31:0]   offset, z, zero_sel, speed_sat;
  logic          out_free;

  // Absolute count from the raw count: optional negate, then optional double.
  always_comb begin
    inv_cnt = cfg.direction_invert ? 32'd0 - in_hw_count : in_hw_count;
    a_in    = cfg.diameter_mode ? {inv_cnt[30:0], 1'b0} : inv_cnt;
  end

  // Input word registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= eps_pkg::kind_t'(in_kind);
      a_r      <= a_in;
      time_r   <= in_time_ms;
      preset_r <= in_preset_value;
    end
  end

  // Elapsed time, and sign and magnitude of the position delta or preset.
  always_comb begin
    dpos = a_r - last_p;
    src  = (kind_r == eps_pkg::KIND_PRESET) ? preset_r : dpos;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dt_r  <= time_r - last_t;
      neg_r <= src[31];
      mag_r <= src[31] ? 32'd0 - src : src;
    end
  end

  // Shared 32x16 multiplier.
  always_comb begin
    case (cmd.mul_sel)
      eps_pkg::MS_PRE: begin
        mul_a = mag_r;
        mul_b = cfg.resolution;
      end
      eps_pkg::MS_NUM: begin
        mul_a = mag_r;
        mul_b = eps_pkg::SPEED_SCALE;
      end
      eps_pkg::MS_DEN: begin
        mul_a = dt_r;
        mul_b = cfg.resolution;
      end
      default: begin
        mul_a = mag_r;
        mul_b = cfg.resolution;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
  end

  // Restoring divider, one quotient bit per cycle; q_r holds the dividend
  // and collects the quotient.
  always_comb begin
    rem_sh = {rem_r, q_r[PW-1]};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_sel == eps_pkg::MS_DEN) begin
        den_r <= prod;
        rem_r <= '0;
      end else begin
        q_r <= prod;
      end
    end else if (cmd.div_step) begin
      rem_r <= ge ? PW'(rem_sh - {1'b0, den_r}) : rem_sh[PW-1:0];
      q_r   <= {q_r[PW-2:0], ge};
    end
  end

  // Signed speed from the quotient, saturated to 32 bits.
  always_comb begin
    if (neg_r) begin
      if ((|q_r[PW-1:32]) || (q_r[31] && (|q_r[30:0]))) begin
        speed_sat = 32'h8000_0000;
      end else begin
        speed_sat = 32'd0 - q_r[31:0];
      end
    end else begin
      speed_sat = (|q_r[PW-1:31]) ? 32'h7FFF_FFFF : q_r[31:0];
    end
  end

  // Preset offset is the Q16.16 product truncated toward zero.
  always_comb begin
    offset = neg_r ? 32'd0 - q_r[47:16] : q_r[47:16];
    z      = (kind_r == eps_pkg::KIND_ZERO) ? a_r : a_r - offset;
  end

  // Next values of the reference and speed state.
  always_comb begin
    abs_zero_next = abs_zero;
    rel_zero_next = rel_zero;
    last_t_next   = last_t;
    last_p_next   = last_p;
    speed_v_next  = speed_v;
    case (kind_r)
      eps_pkg::KIND_SAMPLE: begin
        if (cmd.upd) begin
          speed_v_next = cfg.resolution == '0 ? 32'd0 : speed_sat;
          last_t_next  = time_r;
          last_p_next  = a_r;
        end
      end
      eps_pkg::KIND_ZERO, eps_pkg::KIND_PRESET: begin
        if (cfg.relative_mode) begin
          rel_zero_next = z;
        end else begin
          abs_zero_next = z;
        end
      end
      eps_pkg::KIND_RESET: begin
        abs_zero_next = '0;
        rel_zero_next = '0;
        last_t_next   = time_r;
        last_p_next   = a_r;
        speed_v_next  = '0;
      end
      default: begin
        speed_v_next = speed_v;
      end
    endcase
    zero_sel = cfg.relative_mode ? rel_zero_next : abs_zero_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_zero <= '0;
      rel_zero <= '0;
      last_t   <= '0;
      last_p   <= '0;
      speed_v  <= '0;
    end else if (cmd.commit) begin
      abs_zero <= abs_zero_next;
      rel_zero <= rel_zero_next;
      last_t   <= last_t_next;
      last_p   <= last_p_next;
      speed_v  <= speed_v_next;
    end
  end

  // Output register: holds one finished word until it is taken.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_position      <= a_r - zero_sel;
      out_speed         <= speed_v_next;
      out_speed_updated <= cmd.upd;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.kind     = kind_r;
    sts.win_ok   = dt_r > eps_pkg::SPEED_WINDOW_MS;
    sts.res_zero = cfg.resolution == '0;
    sts.out_free = out_free;
  end

  // A word is only committed into a free output register.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> out_free)
    else $error("commit into an occupied output register");

  // A commit always presents a word in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed word not presented");

  // Resetting all counters clears the stored speed.
  a_reset_speed: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && kind_r == eps_pkg::KIND_RESET) |=> (speed_v == '0 && abs_zero == '0))
    else $error("reset word left speed or zero state");

endmodule

// ===== sv/encoder_position_speed_readout_unit.sv =====
// Channel   Dir  Word contents
// item      in   kind, hw_count, time_ms, preset_value
// result    out  position, speed, speed_updated
// apb       in   direction_invert, diameter_mode, relative_mode, resolution
//
// One result word per item word. Zero and reset words go from evaluation
// straight to commit, and preset words take one multiplier pass first. A sample
// word outside the speed window goes from the window decision to commit, and a
// sample word that refreshes the speed at a nonzero resolution passes twice
// through the shared multiplier and then through the 48-step restoring divider.
// After each commit the controller returns to idle to accept the next word. Reset
// is synchronous and returns the zeros, speed state and registers to their
// defaults. A finished word waits in the output register while the next item
// word is accepted; the block stalls only if a second word finishes.
module encoder_position_speed_readout_unit (
  input  logic                       clk,
  input  logic                       rst,
  eps_in_if.sink                     item,
  eps_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  eps_pkg::cfg_t     cfg;
  eps_pkg::cmd_t     cmd;
  eps_pkg::sts_t     sts;
  eps_pkg::reg_idx_t reg_idx;
  logic              wr_en;
  logic [31:0]       position_w, speed_w;

  // Configuration registers behind the APB port.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = eps_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction_invert <= 1'b0;
      cfg.diameter_mode    <= 1'b0;
      cfg.relative_mode    <= 1'b0;
      cfg.resolution       <= eps_pkg::RESOLUTION_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        eps_pkg::REG_DIRECTION:  cfg.direction_invert <= pwdata[0];
        eps_pkg::REG_DIAMETER:   cfg.diameter_mode    <= pwdata[0];
        eps_pkg::REG_RELATIVE:   cfg.relative_mode    <= pwdata[0];
        eps_pkg::REG_RESOLUTION: cfg.resolution       <= pwdata[15:0];
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      eps_pkg::REG_DIRECTION:  prdata = {31'd0, cfg.direction_invert};
      eps_pkg::REG_DIAMETER:   prdata = {31'd0, cfg.diameter_mode};
      eps_pkg::REG_RELATIVE:   prdata = {31'd0, cfg.relative_mode};
      eps_pkg::REG_RESOLUTION: prdata = {16'd0, cfg.resolution};
    endcase
  end

  eps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eps_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (item.kind),
    .in_hw_count       (item.hw_count),
    .in_time_ms        (item.time_ms),
    .in_preset_value   (item.preset_value),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .out_position      (position_w),
    .out_speed         (speed_w),
    .out_speed_updated (result.speed_updated)
  );

  assign result.position = position_w;
  assign result.speed    = speed_w;

endmodule

// ===== dv/tb_encoder_position_speed_readout_unit.sv =====
module tb_encoder_position_speed_readout_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES       = 8;
  localparam int WORDS_PER_PH = 190;
  // The slowest word is a speed refresh.
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] speed;
    logic        speed_updated;
  } readout_t;

  // Tracks the axis state, predicts one readout per item word and checks
  // each result word against the oldest prediction.
  class readout_scoreboard;
    bit          dir_inv;
    bit          diam;
    bit          rel;
    bit   [15:0] res;
    logic [31:0] abs_zero;
    logic [31:0] rel_zero;
    logic [31:0] speed_time;
    logic [31:0] speed_pos;
    logic [31:0] speed_val;
    readout_t    expected_q[$];
    int          failures;
    int          checked;
    int          refreshes;
    int          saturated;

    function new();
      dir_inv    = 1'b0;
      diam       = 1'b0;
      rel        = 1'b0;
      res        = eps_pkg::RESOLUTION_RST;
      abs_zero   = '0;
      rel_zero   = '0;
      speed_time = '0;
      speed_pos  = '0;
      speed_val  = '0;
      failures   = 0;
      checked    = 0;
      refreshes  = 0;
      saturated  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(eps_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        eps_pkg::REG_DIRECTION:  dir_inv = value[0];
        eps_pkg::REG_DIAMETER:   diam    = value[0];
        eps_pkg::REG_RELATIVE:   rel     = value[0];
        eps_pkg::REG_RESOLUTION: res     = value[15:0];
        default: ;
      endcase
    endfunction

    // Signed count after direction inversion and diameter doubling.
    function logic [31:0] scaled_count(logic [31:0] raw);
      logic [31:0] a;
      a = dir_inv ? 32'd0 - raw : raw;
      if (diam) a = a << 1;
      return a;
    endfunction

    // Q16.16 units to counts, truncated toward zero.
    function logic [31:0] preset_offset(logic [31:0] q);
      bit          neg;
      logic [63:0] mag;
      logic [63:0] prod;
      neg  = q[31];
      mag  = {32'd0, neg ? 32'd0 - q : q};
      prod = (mag * {48'd0, res}) >> 16;
      return neg ? 32'd0 - prod[31:0] : prod[31:0];
    endfunction

    // Counts per window scaled to units per minute, saturated to 32 bits.
    function logic [31:0] rate_per_minute(logic [31:0] dpos, logic [31:0] dt);
      bit          neg;
      logic [63:0] mag;
      logic [63:0] den;
      logic [63:0] quot;
      neg = dpos[31];
      mag = {32'd0, neg ? 32'd0 - dpos : dpos};
      den = {32'd0, dt} * {48'd0, res};
      if (den == 64'd0) return 32'd0;
      quot = (mag * 64'd60000) / den;
      if (neg) begin
        if (quot > 64'h8000_0000) begin
          quot = 64'h8000_0000;
          saturated++;
        end
        return 32'd0 - quot[31:0];
      end
      if (quot > 64'h7FFF_FFFF) begin
        quot = 64'h7FFF_FFFF;
        saturated++;
      end
      return quot[31:0];
    endfunction

    function void note_word(eps_pkg::kind_t k, logic [31:0] raw, logic [31:0] now,
                            logic [31:0] preset);
      logic [31:0] a;
      logic [31:0] dt;
      logic [31:0] base;
      logic [31:0] zero_ref;
      readout_t    w;
      a               = scaled_count(raw);
      w.speed_updated = 1'b0;
      case (k)
        eps_pkg::KIND_SAMPLE: begin
          dt = now - speed_time;
          if (dt > eps_pkg::SPEED_WINDOW_MS) begin
            speed_val       = rate_per_minute(a - speed_pos, dt);
            speed_time      = now;
            speed_pos       = a;
            w.speed_updated = 1'b1;
            refreshes++;
          end
        end
        eps_pkg::KIND_ZERO, eps_pkg::KIND_PRESET: begin
          base = (k == eps_pkg::KIND_ZERO) ? a : a - preset_offset(preset);
          if (rel) rel_zero = base;
          else abs_zero = base;
        end
        default: begin
          abs_zero   = '0;
          rel_zero   = '0;
          speed_time = now;
          speed_pos  = a;
          speed_val  = '0;
        end
      endcase
      zero_ref   = rel ? rel_zero : abs_zero;
      w.position = a - zero_ref;
      w.speed    = speed_val;
      expected_q.push_back(w);
    endfunction

    function void check_word(logic [31:0] pos, logic [31:0] spd, logic upd);
      readout_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with no item pending: position %h speed %h updated %b",
                 $time, pos, spd, upd);
        failures++;
        return;
      end
      w = expected_q.pop_front();
      checked++;
      if (pos !== w.position) begin
        $display("%0t: position expected %h, got %h", $time, w.position, pos);
        failures++;
      end
      if (spd !== w.speed) begin
        $display("%0t: speed expected %h, got %h", $time, w.speed, spd);
        failures++;
      end
      if (upd !== w.speed_updated) begin
        $display("%0t: speed_updated expected %b, got %b", $time, w.speed_updated, upd);
        failures++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [eps_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  bit                         steady;
  logic [31:0]                clock_ms;
  logic [31:0]                axis_count;

  readout_scoreboard sb = new();

  eps_in_if  item_bus ();
  eps_out_if result_bus ();

  encoder_position_speed_readout_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("encoder_position_speed_readout_unit: mismatch");
    $finish;
  end

  // Observe every handshake and register write at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_bus.valid && result_bus.ready)
        sb.check_word(result_bus.position, result_bus.speed, result_bus.speed_updated);
      if (item_bus.valid && item_bus.ready)
        sb.note_word(eps_pkg::kind_t'(item_bus.kind), item_bus.hw_count,
                     item_bus.time_ms, item_bus.preset_value);
      if (psel && penable && pwrite && pready)
        sb.write_reg(eps_pkg::reg_idx_t'(paddr[eps_pkg::ADDR_W-1:2]), pwdata);
    end
  end

  // Outside steady phases, the result side stalls a random number of cycles before each word.
  initial begin
    int stall;
    result_bus.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      @(negedge clk);
    end
  end

  task automatic apb_write(eps_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Unused upper bits of each register word carry random data.
  task automatic program_axis(bit dir_inv, bit diam, bit rel, logic [15:0] res);
    apb_write(eps_pkg::REG_DIRECTION,  {31'($urandom_range(0, 32'h7FFF_FFFF)), dir_inv});
    apb_write(eps_pkg::REG_DIAMETER,   {31'($urandom_range(0, 32'h7FFF_FFFF)), diam});
    apb_write(eps_pkg::REG_RELATIVE,   {31'($urandom_range(0, 32'h7FFF_FFFF)), rel});
    apb_write(eps_pkg::REG_RESOLUTION, {16'($urandom_range(0, 16'hFFFF)), res});
  endtask

  task automatic send_word(eps_pkg::kind_t k, logic [31:0] cnt, logic [31:0] ms,
                           logic [31:0] pre);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.valid        <= 1'b1;
    item_bus.kind         <= k;
    item_bus.hw_count     <= cnt;
    item_bus.time_ms      <= ms;
    item_bus.preset_value <= pre;
    do @(posedge clk); while (!item_bus.ready);
  endtask

  // Hold off the item side until every pending readout is back and the
  // block has had time to finish any refresh still in flight.
  task automatic drain_readouts();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly a moving axis with advancing time, plus some fully random words.
  task automatic random_word();
    int             pick;
    eps_pkg::kind_t k;
    logic [31:0]    pre;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_word(eps_pkg::kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 6) clock_ms += $urandom_range(0, 260);
      else if (pick < 8) clock_ms += $urandom_range(195, 205);
      else if (pick < 9) clock_ms += $urandom_range(0, 5000);
      else clock_ms += $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 7) axis_count += $urandom_range(0, 4000) - 2000;
      else if (pick < 9) axis_count += $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      else axis_count = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 80) k = eps_pkg::KIND_SAMPLE;
      else if (pick < 88) k = eps_pkg::KIND_ZERO;
      else if (pick < 96) k = eps_pkg::KIND_PRESET;
      else k = eps_pkg::KIND_RESET;
      pre = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      send_word(k, axis_count, clock_ms, pre);
    end
  endtask

  initial begin
    bit          dir_set  [PHASES];
    bit          diam_set [PHASES];
    bit          rel_set  [PHASES];
    logic [15:0] res_set  [PHASES];

    dir_set  = '{0, 1, 0, 1, 0, 1, 0, 1};
    diam_set = '{0, 0, 1, 1, 0, 0, 1, 1};
    rel_set  = '{0, 0, 1, 1, 1, 0, 0, 1};
    res_set  = '{16'd1024, 16'd1, 16'd65535, 16'd0, 16'd360,
                 16'($urandom_range(1, 65535)), 16'd1, 16'($urandom_range(1, 65535))};

    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    item_bus.valid        = 1'b0;
    item_bus.kind         = eps_pkg::KIND_SAMPLE;
    item_bus.hw_count     = '0;
    item_bus.time_ms      = '0;
    item_bus.preset_value = '0;
    steady                = 1'b0;
    clock_ms              = 32'd10_000;
    axis_count            = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_readouts();
        program_axis(dir_set[p], diam_set[p], rel_set[p], res_set[p]);
      end
      steady = (p % 3 == 2);

      if (p == 0) begin
        // Reset defaults: window edges, extreme counts, every word kind,
        // extreme presets and time stamps that wrap.
        send_word(eps_pkg::KIND_SAMPLE, 32'd0, 32'd0, 32'd0);
        send_word(eps_pkg::KIND_SAMPLE, 32'd100, 32'd201, 32'd0);
        send_word(eps_pkg::KIND_SAMPLE, 32'h7FFF_FFFF, 32'd401, 32'd0);
        send_word(eps_pkg::KIND_SAMPLE, 32'h8000_0000, 32'd402, 32'd0);
        send_word(eps_pkg::KIND_ZERO, 32'd12345, 32'd403, 32'd0);
        send_word(eps_pkg::KIND_PRESET, 32'd12345, 32'd404, 32'h7FFF_FFFF);
        send_word(eps_pkg::KIND_PRESET, 32'hFFFF_FFFB, 32'd405, 32'h8000_0000);
        send_word(eps_pkg::KIND_PRESET, 32'd7, 32'd406, 32'hFFFF_FFFF);
        send_word(eps_pkg::KIND_RESET, 32'd999, 32'hFFFF_FF00, 32'h1234_5678);
        send_word(eps_pkg::KIND_SAMPLE, 32'd5000, 32'h0000_0010, 32'd0);
        send_word(eps_pkg::KIND_SAMPLE, 32'hFFFF_F448, 32'h0000_0005, 32'd0);
      end else if (p == 1) begin
        // Inverted direction at resolution one drives the speed into both
        // saturation limits, the negative one by exactly half the range.
        send_word(eps_pkg::KIND_RESET, 32'd0, 32'd1000, 32'd0);
        send_word(eps_pkg::KIND_SAMPLE, 32'h7FFF_FFFF, 32'd1201, 32'd0);
        send_word(eps_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 32'd1402, 32'd0);
        send_word(eps_pkg::KIND_SAMPLE, 32'h8000_0000, 32'd1603, 32'd0);
      end else if (p == 3) begin
        // Zero resolution: the refresh yields zero speed and presets add nothing.
        send_word(eps_pkg::KIND_SAMPLE, 32'd777, clock_ms + 32'd100_000, 32'd0);
        send_word(eps_pkg::KIND_PRESET, 32'd777, clock_ms + 32'd100_001, 32'h0040_0000);
      end

      for (int n = 0; n < WORDS_PER_PH; n++) random_word();
    end

    drain_readouts();
    $display("Checked %0d result words over %0d register settings,", sb.checked, PHASES);
    $display("including %0d speed refreshes and %0d saturated speeds.",
             sb.refreshes, sb.saturated);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("encoder_position_speed_readout_unit: match");
    end else begin
      $display("encoder_position_speed_readout_unit: mismatch");
    end
    $finish;
  end

endmodule
